/* hw/rtl/bpd_pkg.sv */
// bpd_pkg: shared types and constants for the button press event detector
// no dependencies; imported by every module of the block

package bpd_pkg;

  // widest threshold set the register map provides
  localparam int MAX_THR   = 4;
  localparam int TIME_W    = 32;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  // descriptor queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  // bit positions in a result descriptor
  localparam int BIT_DOWN  = 0;
  localparam int BIT_UP    = 1;
  localparam int BIT_CLICK = 2;
  localparam int BIT_LONG0 = 3;

  typedef enum logic [1:0] {
    KIND_DOWN  = 2'd0,
    KIND_UP    = 2'd1,
    KIND_CLICK = 2'd2,
    KIND_LONG  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_PRESS_LOW    = 3'd0,
    REG_EVENT_ENABLE = 3'd1,
    REG_LONG_ENABLE  = 3'd2,
    REG_THR0         = 3'd3,
    REG_THR1         = 3'd4,
    REG_THR2         = 3'd5,
    REG_THR3         = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                            press_low;
    logic [2:0]                      event_enable;
    logic [MAX_THR-1:0]              long_enable;
    logic [MAX_THR-1:0][TIME_W-1:0]  long_threshold;
  } cfg_t;

endpackage

/* hw/rtl/bpd_front.sv */
// bpd_front: classifies each poll, keeps press state and builds a result descriptor
// depends on bpd_pkg

module bpd_front import bpd_pkg::*; #(
  parameter int NUM_THR = 4,
  parameter int MW      = 3 + NUM_THR
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic              pin_level,
  input  logic [TIME_W-1:0] now_ms,
  output logic              desc_push,
  output logic [MW-1:0]     desc
);

  logic                pressed_r, pressed_nxt;
  logic [TIME_W-1:0]   start_r, start_nxt;
  logic [NUM_THR-1:0]  fired_r, fired_nxt;

  logic                cur;
  logic                is_press, is_rel, is_hold;
  logic [TIME_W-1:0]   elapsed;
  logic [NUM_THR-1:0]  hit;

  // polarity and edge classification
  assign cur      = cfg.press_low ? ~pin_level : pin_level;
  assign is_press = cur & ~pressed_r;
  assign is_rel   = ~cur & pressed_r;
  assign is_hold  = cur & pressed_r;
  assign elapsed  = now_ms - start_r;

  // thresholds reached while held, once per press
  always_comb begin
    for (int i = 0; i < NUM_THR; i++) begin
      hit[i] = is_hold & cfg.long_enable[i] & ~fired_r[i] &
               (elapsed >= cfg.long_threshold[i]);
    end
  end

  // descriptor: one bit per result, emitted lowest bit first
  always_comb begin
    desc                  = '0;
    desc[BIT_DOWN]        = is_press & cfg.event_enable[0];
    desc[BIT_UP]          = is_rel & cfg.event_enable[1];
    desc[BIT_CLICK]       = is_rel & ~(|fired_r) & cfg.event_enable[2];
    desc[MW-1:BIT_LONG0]  = hit;
  end

  assign desc_push = accept & (|desc);

  // state update on an accepted poll
  always_comb begin
    pressed_nxt = pressed_r;
    start_nxt   = start_r;
    fired_nxt   = fired_r;
    if (accept) begin
      pressed_nxt = cur;
      if (is_press) begin
        start_nxt = now_ms;
        fired_nxt = '0;
      end else begin
        fired_nxt = fired_r | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      start_r   <= '0;
      fired_r   <= '0;
    end else begin
      pressed_r <= pressed_nxt;
      start_r   <= start_nxt;
      fired_r   <= fired_nxt;
    end
  end

endmodule

/* hw/rtl/bpd_queue.sv */
// bpd_queue: short descriptor queue between front and back
// depends on bpd_pkg

module bpd_queue import bpd_pkg::*; #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         q_full,
  output logic         q_empty
);

  logic [W-1:0]      mem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  // pointer and fill count
  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/bpd_back.sv */
// bpd_back: serializes descriptors into result transfers through an output register
// depends on bpd_pkg

module bpd_back import bpd_pkg::*; #(
  parameter int MW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [MW-1:0] q_data,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [1:0]    event_kind,
  output logic [1:0]    threshold_index,
  output logic          last_of_run
);

  logic [MW-1:0] cur_r, cur_nxt;
  logic          ov_r, ov_nxt;
  kind_t         kind_r, kind_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          last_r, last_nxt;

  logic [MW-1:0] src, rest;
  logic          from_q, slot_free, found;
  kind_t         sel_kind;
  logic [1:0]    sel_idx;

  // work from the held descriptor, else the queue head
  assign from_q    = (cur_r == '0);
  assign src       = from_q ? (q_empty ? '0 : q_data) : cur_r;
  assign slot_free = ~ov_r | pop;

  // pick the lowest pending result
  always_comb begin
    found    = 1'b0;
    sel_kind = KIND_DOWN;
    sel_idx  = '0;
    rest     = src;
    for (int i = 0; i < MW; i++) begin
      if (!found && src[i]) begin
        found   = 1'b1;
        rest[i] = 1'b0;
        if (i == BIT_DOWN) begin
          sel_kind = KIND_DOWN;
        end else if (i == BIT_UP) begin
          sel_kind = KIND_UP;
        end else if (i == BIT_CLICK) begin
          sel_kind = KIND_CLICK;
        end else begin
          sel_kind = KIND_LONG;
          sel_idx  = 2'(i - BIT_LONG0);
        end
      end
    end
  end

  // output register and descriptor update
  always_comb begin
    cur_nxt  = cur_r;
    ov_nxt   = ov_r & ~pop;
    kind_nxt = kind_r;
    idx_nxt  = idx_r;
    last_nxt = last_r;
    q_pop    = 1'b0;
    if (slot_free && found) begin
      ov_nxt   = 1'b1;
      kind_nxt = sel_kind;
      idx_nxt  = sel_idx;
      last_nxt = (rest == '0);
      cur_nxt  = rest;
      q_pop    = from_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
  end

  assign empty           = ~ov_r;
  assign event_kind      = kind_r;
  assign threshold_index = idx_r;
  assign last_of_run     = last_r;

endmodule

/* hw/rtl/button_press_event_detector.sv */
// button_press_event_detector: top level with register file, front, queue and back
// depends on bpd_pkg, bpd_front, bpd_queue, bpd_back
// path: a poll's results pass through the descriptor queue, then the back end's output register
// throughput: one poll per cycle while the queue has room; one result per cycle out
// of the back end while the receiver pops; a poll has up to 4 results, one transfer each
// reset: synchronous active low; registers return to defaults, no press held, queue empty

module button_press_event_detector import bpd_pkg::*; #(
  parameter int NUM_THRESHOLDS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // poll channel
  input  logic              push,
  output logic              full,
  input  logic              in_pin_level,
  input  logic [TIME_W-1:0] in_now_ms,
  // result channel
  input  logic              pop,
  output logic              empty,
  output logic [1:0]        out_event_kind,
  output logic [1:0]        out_threshold_index,
  output logic              out_last_of_run,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int MW = 3 + NUM_THRESHOLDS;

  cfg_t           cfg_r, cfg_nxt;
  reg_idx_t       ridx;
  logic           wr_fire;
  logic           accept;
  logic           desc_push;
  logic [MW-1:0]  desc;
  logic [MW-1:0]  q_data;
  logic           q_full, q_empty, q_pop;

  // register file
  assign pready  = 1'b1;
  assign ridx    = reg_idx_t'(paddr[4:2]);
  assign wr_fire = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_fire) begin
      unique case (ridx)
        REG_PRESS_LOW:    cfg_nxt.press_low         = pwdata[0];
        REG_EVENT_ENABLE: cfg_nxt.event_enable      = pwdata[2:0];
        REG_LONG_ENABLE:  cfg_nxt.long_enable       = pwdata[MAX_THR-1:0];
        REG_THR0:         cfg_nxt.long_threshold[0] = pwdata;
        REG_THR1:         cfg_nxt.long_threshold[1] = pwdata;
        REG_THR2:         cfg_nxt.long_threshold[2] = pwdata;
        REG_THR3:         cfg_nxt.long_threshold[3] = pwdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_low      <= 1'b1;
      cfg_r.event_enable   <= 3'b111;
      cfg_r.long_enable    <= '0;
      cfg_r.long_threshold <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register readback
  always_comb begin
    unique case (ridx)
      REG_PRESS_LOW:    prdata = CFG_DW'(cfg_r.press_low);
      REG_EVENT_ENABLE: prdata = CFG_DW'(cfg_r.event_enable);
      REG_LONG_ENABLE:  prdata = CFG_DW'(cfg_r.long_enable);
      REG_THR0:         prdata = cfg_r.long_threshold[0];
      REG_THR1:         prdata = cfg_r.long_threshold[1];
      REG_THR2:         prdata = cfg_r.long_threshold[2];
      REG_THR3:         prdata = cfg_r.long_threshold[3];
      default:          prdata = '0;
    endcase
  end

  // poll transfer
  assign full   = q_full;
  assign accept = push & ~q_full;

  bpd_front #(
    .NUM_THR (NUM_THRESHOLDS),
    .MW      (MW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .pin_level (in_pin_level),
    .now_ms    (in_now_ms),
    .desc_push (desc_push),
    .desc      (desc)
  );

  bpd_queue #(
    .W (MW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (desc_push),
    .wr_data (desc),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  bpd_back #(
    .MW (MW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_data),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .event_kind      (out_event_kind),
    .threshold_index (out_threshold_index),
    .last_of_run     (out_last_of_run)
  );

endmodule

/* tb/button_press_event_detector_tb.sv */
// button_press_event_detector_tb: self-checking bench for the button press event detector
// depends on bpd_pkg and button_press_event_detector; directed table, then random press runs
// each result transfer is checked against an in-bench model of the press logic, or against a typed row's results

`timescale 1ns / 100ps

module button_press_event_detector_tb;
  import bpd_pkg::*;

  localparam int N_THR         = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_POLLS   = 28;
  localparam int CYCLE_LIMIT   = 400000;

  // one expected or observed result
  typedef struct packed {
    kind_t      kind;
    logic [1:0] idx;
    logic       last;
  } btn_event_t;

  // one row of the directed table: a register write or a poll
  typedef struct packed {
    logic                  is_cfg;
    reg_idx_t              ridx;
    logic                  pin;
    logic [31:0]           word;
    logic                  typed;
    logic [1:0]            n_typed;
    btn_event_t [1:0]      typed_evs;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              in_pin_level = 1'b0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic              pop = 1'b0;
  logic              empty;
  logic [1:0]        out_event_kind;
  logic [1:0]        out_threshold_index;
  logic              out_last_of_run;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // register shadow, as seen by the button model
  logic              sh_press_low = 1'b1;
  logic [2:0]        sh_event_en = 3'h7;
  logic [3:0]        sh_long_en = 4'h0;
  logic [31:0]       sh_thr [N_THR] = '{default: '0};

  // button model state
  logic              btn_down = 1'b0;
  logic [31:0]       press_t = '0;
  logic [N_THR-1:0]  fired = '0;
  int                pred_n;
  btn_event_t        pred_evs [4];

  btn_event_t        pending_events [$];
  stim_row_t         dir_tab [$];
  btn_event_t        want;
  int                err_cnt = 0;
  int                polls_sent = 0;
  int                cycle_cnt = 0;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                hold_left = 0;
  bit                hold_req = 1'b0;

  button_press_event_detector #(
    .NUM_THRESHOLDS (N_THR)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_pin_level        (in_pin_level),
    .in_now_ms           (in_now_ms),
    .pop                 (pop),
    .empty               (empty),
    .out_event_kind      (out_event_kind),
    .out_threshold_index (out_threshold_index),
    .out_last_of_run     (out_last_of_run),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // append one event to the model's output for this poll
  function automatic void note_event(kind_t k, logic [1:0] i);
    pred_evs[pred_n] = '{k, i, 1'b0};
    pred_n++;
  endfunction

  // button model: advance press state by one poll, fill pred_evs
  function automatic void press_model(logic pin, logic [31:0] now);
    logic        cur;
    logic [31:0] held;
    pred_n = 0;
    cur = sh_press_low ? !pin : pin;
    if (cur && !btn_down) begin
      btn_down = 1'b1;
      press_t = now;
      fired = '0;
      if (sh_event_en[0]) note_event(KIND_DOWN, 2'd0);
    end else if (!cur && btn_down) begin
      btn_down = 1'b0;
      if (sh_event_en[1]) note_event(KIND_UP, 2'd0);
      // click only if no threshold fired, enabled now or not
      if (fired == '0 && sh_event_en[2]) note_event(KIND_CLICK, 2'd0);
    end else if (cur && btn_down) begin
      held = now - press_t;
      for (int i = 0; i < N_THR; i++) begin
        if (sh_long_en[i] && held >= sh_thr[i] && !fired[i]) begin
          fired[i] = 1'b1;
          note_event(KIND_LONG, 2'(i));
        end
      end
    end
    if (pred_n > 0) pred_evs[pred_n-1].last = 1'b1;
  endfunction

  function automatic btn_event_t ev(kind_t k, logic [1:0] i, logic l);
    btn_event_t e;
    e.kind = k;
    e.idx = i;
    e.last = l;
    return e;
  endfunction

  function automatic stim_row_t row_cfg(reg_idx_t r, logic [31:0] v);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.ridx = r;
    s.word = v;
    return s;
  endfunction

  function automatic stim_row_t row_poll(logic pin, logic [31:0] now);
    stim_row_t s;
    s = '0;
    s.pin = pin;
    s.word = now;
    return s;
  endfunction

  function automatic stim_row_t row_typed(logic pin, logic [31:0] now, logic [1:0] n,
                                          btn_event_t e0, btn_event_t e1);
    stim_row_t s;
    s = row_poll(pin, now);
    s.typed = 1'b1;
    s.n_typed = n;
    s.typed_evs[0] = e0;
    s.typed_evs[1] = e1;
    return s;
  endfunction

  function automatic logic [31:0] hold_step();
    // mostly short steps, now and then a huge jump that may wrap
    return ($urandom_range(11) == 0) ? $urandom() : $urandom_range(60);
  endfunction

  function automatic void check_field(string what, logic [1:0] exp_val, logic [1:0] act_val);
    if (act_val !== exp_val) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
    end
  endfunction

  // result side: check each transfer, then pick pop for the next edge
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_events.size() == 0) begin
        err_cnt++;
        $display("%0t: result with no expectation waiting, expected none, actual kind %0d",
                 $time, out_event_kind);
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, out_event_kind);
        check_field("threshold_index", want.idx, out_threshold_index);
        check_field("last_of_run", {1'b0, want.last}, {1'b0, out_last_of_run});
      end
    end
    if (hold_req) begin
      hold_left = 120;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one poll transfer; typed rows override the model's results
  task automatic send_poll(logic pin, logic [31:0] now, logic typed = 1'b0,
                           logic [1:0] n_typed = '0, btn_event_t [1:0] typed_evs = '0);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_pin_level <= pin;
    in_now_ms <= now;
    do @(posedge clk); while (full);
    press_model(pin, now);
    polls_sent++;
    if (typed) begin
      for (int i = 0; i < n_typed; i++) pending_events.push_back(typed_evs[i]);
    end else begin
      for (int i = 0; i < pred_n; i++) pending_events.push_back(pred_evs[i]);
    end
  endtask

  // stop polling and wait for the block to drain
  task automatic settle();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup, access, then return to idle
  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(4 * int'(r));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_PRESS_LOW:    sh_press_low = v[0];
      REG_EVENT_ENABLE: sh_event_en = v[2:0];
      REG_LONG_ENABLE:  sh_long_en = v[3:0];
      default:          sh_thr[int'(r) - int'(REG_THR0)] = v;
    endcase
    @(posedge clk);
  endtask

  // settings for one random phase, the first two are the extremes
  task automatic pick_settings(int p);
    logic [31:0] thr_q [$];
    logic        al;
    logic [2:0]  en;
    logic [3:0]  le;
    case (p)
      0: begin
        al = 1'b0;
        en = 3'h7;
        le = 4'hf;
        thr_q = '{32'h0, 32'h0, 32'h0, 32'h0};
      end
      1: begin
        al = 1'b1;
        en = 3'h0;
        le = 4'hf;
        thr_q = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      end
      default: begin
        al = 1'($urandom_range(1));
        en = 3'($urandom_range(7));
        le = 4'($urandom_range(15));
        repeat (N_THR) thr_q.push_back(($urandom_range(7) == 0) ? $urandom()
                                                                 : $urandom_range(150));
        thr_q.sort();
      end
    endcase
    for (int i = 0; i < N_THR; i++) write_reg(reg_idx_t'(int'(REG_THR0) + i), thr_q[i]);
    write_reg(REG_PRESS_LOW, {31'b0, al});
    write_reg(REG_EVENT_ENABLE, {29'b0, en});
    write_reg(REG_LONG_ENABLE, {28'b0, le});
  endtask

  // one press run with random timing, sometimes noise, sometimes no release
  task automatic press_burst();
    logic [31:0] t;
    logic        on_lvl;
    int          holds;
    t = $urandom();
    on_lvl = !sh_press_low;
    holds = $urandom_range(6);
    if ($urandom_range(7) == 0) send_poll(1'($urandom_range(1)), $urandom());
    if ($urandom_range(1) == 1) send_poll(!on_lvl, t - 32'd1);
    send_poll(on_lvl, t);
    repeat (holds) begin
      t += hold_step();
      send_poll(on_lvl, t);
    end
    if ($urandom_range(9) != 0) begin
      t += hold_step();
      send_poll(!on_lvl, t);
    end
  endtask

  initial begin
    int target;

    // directed table; typed rows carry results read straight off the rules
    dir_tab = '{
      // reset settings: active low, all events, no long press
      row_typed(1'b1, 32'd0,   2'd0, '0, '0),
      row_typed(1'b0, 32'd100, 2'd1, ev(KIND_DOWN, 2'd0, 1'b1), '0),
      row_typed(1'b0, 32'd200, 2'd0, '0, '0),
      row_typed(1'b1, 32'd300, 2'd2, ev(KIND_UP, 2'd0, 1'b0), ev(KIND_CLICK, 2'd0, 1'b1)),
      // active high, all four thresholds, two equal, one at the top
      row_cfg(REG_PRESS_LOW, 32'd0),
      row_cfg(REG_LONG_ENABLE, 32'hf),
      row_cfg(REG_THR0, 32'd0),
      row_cfg(REG_THR1, 32'd10),
      row_cfg(REG_THR2, 32'd10),
      row_cfg(REG_THR3, 32'hffff_ffff),
      row_typed(1'b1, 32'hffff_ffff, 2'd1, ev(KIND_DOWN, 2'd0, 1'b1), '0),
      row_typed(1'b1, 32'hffff_ffff, 2'd1, ev(KIND_LONG, 2'd0, 1'b1), '0),
      row_poll(1'b1, 32'h0000_000f),
      // elapsed time wraps around to the top threshold
      row_poll(1'b1, 32'hffff_fffe),
      row_typed(1'b0, 32'd5, 2'd1, ev(KIND_UP, 2'd0, 1'b1), '0),
      // edge events disabled, long press still reported
      row_cfg(REG_EVENT_ENABLE, 32'd0),
      row_cfg(REG_LONG_ENABLE, 32'd1),
      row_cfg(REG_THR0, 32'd5),
      row_poll(1'b1, 32'd100),
      row_poll(1'b1, 32'd110),
      row_poll(1'b0, 32'd120),
      // long enable dropped while held: no click on release
      row_cfg(REG_EVENT_ENABLE, 32'd7),
      row_poll(1'b1, 32'd200),
      row_poll(1'b1, 32'd205),
      row_cfg(REG_LONG_ENABLE, 32'd0),
      row_poll(1'b0, 32'd300),
      row_cfg(REG_PRESS_LOW, 32'd1),
      row_poll(1'b0, 32'h8000_0000),
      row_poll(1'b1, 32'h7fff_ffff)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) begin
        settle();
        write_reg(dir_tab[k].ridx, dir_tab[k].word);
      end else begin
        send_poll(dir_tab[k].pin, dir_tab[k].word, dir_tab[k].typed,
                  dir_tab[k].n_typed, dir_tab[k].typed_evs);
      end
    end

    // random phases, each with its own settings and idle pattern
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      pick_settings(p);
      // long receiver hold-off while polls keep coming, with every result enabled
      if (p == 0) hold_req = 1'b1;
      target = polls_sent + PHASE_POLLS;
      while (polls_sent < target) press_burst();
    end

    settle();
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
